/* hdl/box_blur_zero_padded_macros.svh */
// Assertion macros for the box blur block.
// Used by files that check their own logic; needs a clock named clk and reset rst.
`ifndef BOX_BLUR_ZERO_PADDED_MACROS_SVH
`define BOX_BLUR_ZERO_PADDED_MACROS_SVH

// condition holds at every edge out of reset
`define BB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// a implies c in the same cycle
`define BB_ASSERT_IMP(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// a implies c in the next cycle
`define BB_ASSERT_NEXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

/* hdl/bb_pkg.sv */
// Shared types and constants for the box blur block.
// No dependencies.
package bb_pkg;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_KERNEL = 15;
  localparam int MAX_HEIGHT     = 1024;
  localparam int DIM_W   = 11;   // width and height register bits
  localparam int KER_W   = 4;    // kernel register bits
  localparam int CNT_W   = 22;   // pixel counters
  localparam int POS_W   = 13;   // signed tap position
  localparam int SUM_W   = 16;
  localparam int PADDR_W = 4;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERNEL = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [KER_W-1:0] ksize;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM, ST_DRAIN, ST_DIV, ST_DONE
  } state_t;
endpackage

/* hdl/box_blur_zero_padded.sv */
// Top level: sequencer over the line store, window accumulation and divide.
// Uses bb_pkg, bb_regs, bb_ram, bb_div and the assertion macros header.
// An item that yields an output walks the K*K window through the line-store
// read port, then waits on the serial divide.
// Throughput: one item at a time; items with no output leave the block idle.
// Reset: synchronous; registers return to 512x512, K=3, counters cleared.
// The line store needs no clearing pass: only pixels of the current frame are read.
`include "box_blur_zero_padded_macros.svh"
module box_blur_zero_padded
  import bb_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [7:0]         pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         blurred,
  output logic               frame_last
);
  localparam int AW = $clog2(MAX_KERNEL * MAX_WIDTH + MAX_KERNEL);

  cfg_t cfg;
  logic cfg_hit;
  state_t state, state_next;

  logic [CNT_W-1:0] inputs_seen, outputs_given, total, lead, seen_inc, given_inc;
  logic [DIM_W-1:0] col, row;
  logic [2:0]       r;
  logic [KER_W-1:0] dx, dy;
  logic signed [POS_W-1:0] tx, ty;
  logic [AW-1:0]    tap_addr;
  logic [7:0]       rdata;
  logic             rd_ok;
  logic             tap_ok, last_dx, last_tap;
  logic [SUM_W-1:0] acc, acc_sum, quotient;
  logic             div_start, div_done;
  logic             accept, px_take, start, finish, is_last;

  bb_regs #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL)) u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg, .cfg_hit
  );

  bb_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_store (
    .clk, .we(px_take), .waddr(inputs_seen[AW-1:0]), .wdata(pixel),
    .raddr(tap_addr), .rdata
  );

  bb_div u_div (
    .clk, .rst, .start(div_start), .dividend(acc_sum),
    .divisor(8'(cfg.ksize) * 8'(cfg.ksize)), .done(div_done), .quotient
  );

  // frame geometry
  assign r         = cfg.ksize[3:1];
  assign total     = CNT_W'(cfg.width) * CNT_W'(cfg.height);
  assign lead      = CNT_W'(r) * CNT_W'(cfg.width) + CNT_W'(r);
  assign seen_inc  = inputs_seen + 1'b1;
  assign given_inc = outputs_given + 1'b1;
  assign is_last   = given_inc >= total;

  // item decode
  assign accept  = in_valid && in_ready;
  assign px_take = accept && !command && (inputs_seen < total);
  assign start   = (px_take && (outputs_given < total) && (outputs_given + lead < seen_inc)) ||
                   (accept && command && (inputs_seen >= total) && (outputs_given < total));

  // window walk
  assign last_dx  = dx == cfg.ksize - 1'b1;
  assign last_tap = last_dx && (dy == cfg.ksize - 1'b1);
  assign tap_ok   = !tx[POS_W-1] && (tx < $signed({2'b0, cfg.width})) &&
                    !ty[POS_W-1] && (ty < $signed({2'b0, cfg.height}));
  assign acc_sum  = acc + (rd_ok ? SUM_W'(rdata) : SUM_W'(0));

  assign div_start = state == ST_DRAIN;
  assign finish    = ((state == ST_DIV) && div_done && (!out_valid || out_ready)) ||
                     ((state == ST_DONE) && out_ready);
  assign in_ready  = state == ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_SUM;
      ST_SUM:   if (last_tap) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) state_next = finish ? ST_IDLE : ST_DONE;
      end
      ST_DONE:  if (finish) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // frame counters and output position
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      inputs_seen   <= '0;
      outputs_given <= '0;
      col           <= '0;
      row           <= '0;
    end else if (px_take) begin
      inputs_seen <= seen_inc;
    end else if (finish) begin
      if (is_last) begin
        inputs_seen   <= '0;
        outputs_given <= '0;
        col           <= '0;
        row           <= '0;
      end else begin
        outputs_given <= given_inc;
        if (col == cfg.width - 1'b1) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  // tap address and accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else if (state == ST_IDLE) begin
      rd_ok <= 1'b0;
      if (start) begin
        acc      <= '0;
        dx       <= '0;
        dy       <= '0;
        tap_addr <= outputs_given[AW-1:0] - lead[AW-1:0];
        tx       <= $signed({2'b0, col}) - $signed({10'b0, r});
        ty       <= $signed({2'b0, row}) - $signed({10'b0, r});
      end
    end else if (state == ST_SUM) begin
      rd_ok <= tap_ok;
      acc   <= acc_sum;
      if (last_dx) begin
        dx       <= '0;
        dy       <= dy + 1'b1;
        tx       <= $signed({2'b0, col}) - $signed({10'b0, r});
        ty       <= ty + 1'b1;
        tap_addr <= tap_addr + AW'(cfg.width) - AW'({r, 1'b0});
      end else begin
        dx       <= dx + 1'b1;
        tx       <= tx + 1'b1;
        tap_addr <= tap_addr + 1'b1;
      end
    end else begin
      rd_ok <= 1'b0;
      if (state == ST_DRAIN) begin
        acc <= acc_sum;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      blurred    <= quotient[7:0];
      frame_last <= is_last;
    end
  end

  `BB_ASSERT_ALWAYS(a_seen_in_frame, inputs_seen <= total, "pixel count beyond frame")
  `BB_ASSERT_ALWAYS(a_given_in_frame, outputs_given < total, "output count beyond frame")
  `BB_ASSERT_IMP(a_done_holds, state == ST_DONE, out_valid, "waiting with no pending item")
  `BB_ASSERT_NEXT(a_sum_flow, state == ST_SUM, (state == ST_SUM) || (state == ST_DRAIN),
                  "window walk left early")
endmodule

/* hdl/bb_ram.sv */
// Generic simple dual-port RAM with registered read.
// No dependencies.
module bb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/bb_div.sv */
// Serial restoring divider, one quotient bit per cycle.
// Uses bb_pkg for the dividend width.
module bb_div
  import bb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [7:0]       divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);
  localparam int CW = $clog2(SUM_W);

  logic [8:0]    rem;
  logic [8:0]    trial;
  logic [7:0]    dvs;
  logic [CW-1:0] count;
  logic          busy;

  assign trial = {rem[7:0], quotient[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CW'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift and subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem      <= trial - {1'b0, dvs};
        quotient <= {quotient[SUM_W-2:0], 1'b1};
      end else begin
        rem      <= trial;
        quotient <= {quotient[SUM_W-2:0], 1'b0};
      end
    end
  end
endmodule

/* hdl/bb_regs.sv */
// Configuration registers behind the APB-style port.
// Uses bb_pkg for cfg_t and register indexes.
module bb_regs
  import bb_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg,
  output logic               cfg_hit
);
  localparam int KTOP = (MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1;

  logic             wr;
  logic [1:0]       idx;
  logic [DIM_W-1:0] wv;
  logic [DIM_W-1:0] hv;
  logic [KER_W-1:0] kv;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  // clamp incoming values
  always_comb begin
    wv = pwdata[DIM_W-1:0];
    if (wv == '0) begin
      wv = DIM_W'(1);
    end else if ({2'b0, wv} > 13'(MAX_WIDTH)) begin
      wv = DIM_W'(MAX_WIDTH);
    end
    hv = pwdata[DIM_W-1:0];
    if (hv == '0) begin
      hv = DIM_W'(1);
    end else if (hv > DIM_W'(MAX_HEIGHT)) begin
      hv = DIM_W'(MAX_HEIGHT);
    end
    kv = pwdata[KER_W-1:0];
    if ({2'b0, kv} > 6'(KTOP)) begin
      kv = KER_W'(KTOP);
    end
  end

  // even kernel sizes and unknown indexes are dropped
  assign cfg_hit = wr && ((idx == REG_WIDTH) || (idx == REG_HEIGHT) ||
                          ((idx == REG_KERNEL) && pwdata[0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= DIM_W'(512);
      cfg.height <= DIM_W'(512);
      cfg.ksize  <= KER_W'(3);
    end else if (cfg_hit) begin
      unique case (idx)
        REG_WIDTH:  cfg.width  <= wv;
        REG_HEIGHT: cfg.height <= hv;
        default:    cfg.ksize  <= kv;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = {21'b0, cfg.width};
      REG_HEIGHT: prdata = {21'b0, cfg.height};
      REG_KERNEL: prdata = {28'b0, cfg.ksize};
      default:    prdata = '0;
    endcase
  end
endmodule

/* tb/sv/blur_scoreboard.sv */
// Scoreboard for the zero-padded box blur: predicts each window mean and frame marker.
// Depends on nothing; it is compiled ahead of tb_top and used there.
`timescale 1ns / 100ps
class blur_scoreboard;
  localparam int RING_DEPTH = 15 * 1024 + 15;

  typedef struct {
    logic [7:0] blurred;
    logic       frame_last;
  } blur_result_t;

  int unsigned   img_w, img_h, ksize;
  int unsigned   pixels_in, means_out;
  byte unsigned  ring[RING_DEPTH];
  blur_result_t  awaited[$];
  int            errors;

  function new();
    img_w = 512;
    img_h = 512;
    ksize = 3;
    pixels_in = 0;
    means_out = 0;
    errors = 0;
    foreach (ring[i]) ring[i] = 0;
  endfunction

  function int unsigned frame_size();
    return img_w * img_h;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  // register write as seen by the block; a dropped write keeps the frame
  function void write_reg(int idx, logic [31:0] value);
    int unsigned v;
    if (idx == 0 || idx == 1) begin
      v = value & 32'h7FF;
      if (v == 0) v = 1;
      if (v > 1024) v = 1024;
      if (idx == 0) img_w = v;
      else img_h = v;
    end else if (idx == 2) begin
      v = value & 32'hF;
      if (v[0] == 1'b0) return;
      ksize = v;
    end else begin
      return;
    end
    pixels_in = 0;
    means_out = 0;
  endfunction

  // truncated mean of the window round output n, zero outside the image
  function int unsigned window_mean(int unsigned n);
    int r, row, col, y, x;
    int unsigned acc;
    r = (ksize - 1) / 2;
    row = n / img_w;
    col = n % img_w;
    acc = 0;
    for (int dy = -r; dy <= r; dy++) begin
      y = row + dy;
      if (y < 0 || y >= int'(img_h)) continue;
      for (int dx = -r; dx <= r; dx++) begin
        x = col + dx;
        if (x < 0 || x >= int'(img_w)) continue;
        acc += ring[(y * img_w + x) % RING_DEPTH];
      end
    end
    return acc / (ksize * ksize);
  endfunction

  function void note_input(logic cmd, logic [7:0] pix);
    int unsigned lead;
    blur_result_t res;
    lead = ((ksize - 1) / 2) * img_w + (ksize - 1) / 2;
    if (cmd == 1'b0) begin
      if (pixels_in >= frame_size()) return;
      ring[pixels_in % RING_DEPTH] = pix;
      pixels_in++;
      if (means_out >= frame_size() || means_out + lead >= pixels_in) return;
    end else begin
      if (pixels_in < frame_size() || means_out >= frame_size()) return;
    end
    res.blurred = window_mean(means_out);
    means_out++;
    res.frame_last = (means_out >= frame_size());
    if (res.frame_last) begin
      pixels_in = 0;
      means_out = 0;
    end
    awaited.push_back(res);
  endfunction

  function void check_result(logic [7:0] blurred, logic frame_last);
    blur_result_t res;
    if (awaited.size() == 0) begin
      $error("unexpected output: blurred %0d frame_last %0d", blurred, frame_last);
      errors++;
      return;
    end
    res = awaited.pop_front();
    if (blurred !== res.blurred) begin
      $error("blurred: expected %0d, actual %0d", res.blurred, blurred);
      errors++;
    end
    if (frame_last !== res.frame_last) begin
      $error("frame_last: expected %0d, actual %0d", res.frame_last, frame_last);
      errors++;
    end
  endfunction
endclass

/* tb/sv/tb_top.sv */
// Testbench top for box_blur_zero_padded: APB set-up, pixel and flush traffic, checking.
// Depends on bb_pkg, the block's RTL and blur_scoreboard.
`timescale 1ns / 100ps
module tb_top
  import bb_pkg::*;
;

  localparam int SETTLE = 300;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_ready, command;
  logic [7:0] pixel;
  logic out_valid, out_ready, frame_last;
  logic [7:0] blurred;

  blur_scoreboard sb;
  bit calm;
  int hold_cycles;
  int sent;

  box_blur_zero_padded dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .pixel(pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .blurred(blurred), .frame_last(frame_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #32_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // accepted items and results
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_input(command, pixel);
    if (!rst && out_valid && out_ready) sb.check_result(blurred, frame_last);
  end

  // receiver: random stall bursts, one long hold when asked
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 12);
        out_ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] w, logic [31:0] h, logic [31:0] k);
    drain();
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_KERNEL, k);
  endtask

  // one item, valid held until accepted, optional gap after it
  task automatic send_item(logic cmd, logic [7:0] pix);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    command = cmd;
    pixel = pix;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // mostly well-formed frames with random pixels, a little stray traffic
  task automatic run_frames(int budget);
    logic cmd;
    for (int i = 0; i < budget; i++) begin
      if (sb.pixels_in < sb.frame_size()) cmd = ($urandom_range(0, 19) == 0);
      else cmd = ($urandom_range(0, 9) != 0);
      send_item(cmd, 8'($urandom));
    end
    idle_input();
  endtask

  initial begin
    int unsigned w, h, k, pick;
    sb = new();
    calm = 1'b0;
    hold_cycles = 0;
    sent = 0;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; command = 1'b0; pixel = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: a few pixels, none of which can yield an output yet
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'h00);   // flush before frame end: ignored
    idle_input();

    // single pixel image, 1x1 kernel
    configure(32'h1, 32'h1, 32'h1);
    send_item(1'b0, 8'hFF);
    send_item(1'b1, 8'h00);   // nothing left to drain
    idle_input();

    // image smaller than the kernel: every output comes from flushes
    configure(32'h3, 32'h2, 32'hF);
    for (int i = 0; i < 6; i++) send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h55);   // pixel past frame end: ignored
    for (int i = 0; i < 6; i++) send_item(1'b1, 8'hAA);
    idle_input();

    // zero sizes act as one; even kernels, zero among them, are ignored
    configure(32'hFFFF_F800, 32'h0, 32'hD);
    reg_write(REG_KERNEL, 32'h4);
    reg_write(REG_KERNEL, 32'h0);
    reg_write(2'd3, 32'hFFFF_FFFF);
    send_item(1'b0, 8'h80);
    send_item(1'b1, 8'h00);
    idle_input();

    // oversized width saturates; frame abandoned by the next write
    configure(32'h7FF, 32'h7FF, 32'h3);
    for (int i = 0; i < 3; i++) send_item(1'b0, 8'($urandom));
    idle_input();

    // random settings, long receiver hold in the first one
    sent = 0;
    for (int phase = 0; sent < 1050; phase++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        w = ($urandom_range(0, 1) != 0) ? 1024 : 2047;
        h = 1;
      end else if (pick == 1) begin
        w = 1;
        h = ($urandom_range(0, 1) != 0) ? 1024 : 2047;
      end else begin
        w = $urandom_range(1, 24);
        h = $urandom_range(1, 12);
      end
      k = ($urandom_range(0, 5) == 0) ? 15 : 2 * $urandom_range(0, 6) + 1;
      // every pixel yields an output here, so the held receiver fills the block
      if (phase == 0) k = 1;
      configure(w, h, k);
      if (phase == 0) hold_cycles = 400;
      if (sent > 900) calm = 1'b1;
      run_frames($urandom_range(20, 160));
    end

    drain();
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

/* box_blur_zero_padded.f */
+incdir+hdl
hdl/bb_pkg.sv
hdl/bb_ram.sv
hdl/bb_div.sv
hdl/bb_regs.sv
hdl/box_blur_zero_padded.sv
tb/sv/blur_scoreboard.sv
tb/sv/tb_top.sv
